[rtl/tces_pkg.sv]
// Shared constants, types and helper functions for the execute step unit.
// Depends on nothing; tces_regfile and toy_cpu_execute_step_unit import it.
`timescale 1ns / 1ps

package tces_pkg;

	localparam int MEM_WORDS  = 256;
	localparam int DATA_WIDTH = 32;
	localparam int OUT_W      = 32;
	localparam int RF_DEPTH   = 8;
	localparam int RF_AW      = 3;
	localparam int MEM_AW     = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam int CLR_LEN    = (MEM_WORDS > RF_DEPTH) ? MEM_WORDS : RF_DEPTH;
	localparam int CLR_W      = $clog2(CLR_LEN);

	typedef logic [DATA_WIDTH-1:0] word_t;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_SUB   = 2'd1,
		OP_LOAD  = 2'd2,
		OP_STORE = 2'd3
	} op_t;

	typedef struct packed {
		logic             en;
		logic [RF_AW-1:0] idx;
		word_t            data;
	} rf_wr_t;

	// Register contents after reset.
	function automatic word_t rf_reset_value(logic [RF_AW-1:0] idx);
		word_t v;
		case (idx)
			3'd1:    v = DATA_WIDTH'(4);
			3'd2:    v = DATA_WIDTH'(9);
			3'd3:    v = DATA_WIDTH'(10);
			default: v = '0;
		endcase
		return v;
	endfunction

	// An address is valid when it is non-negative as a signed word and below MEM_WORDS.
	function automatic logic addr_in_range(word_t a);
		return !a[DATA_WIDTH-1] && (64'(a) < 64'(MEM_WORDS));
	endfunction

endpackage

[rtl/toy_cpu_execute_step_unit.sv]
// Execute step unit of a tiny load/store machine: one 8-bit instruction per beat in,
// one report beat out. Depends on tces_pkg, tces_regfile and tces_ram.
`timescale 1ns / 1ps

// Each input beat is one instruction: bits 7:6 select add, sub, load or store, bits 5:3
// name register a and bits 2:0 register b. Add and sub write a op b into register a,
// wrapping at the word width. Load copies the data memory word addressed by register b
// into register a, or all ones when that address is negative or beyond the memory.
// Store copies register a into that word and is dropped when the address is out of range.
// The unit takes one instruction per clock cycle while the output side is not stalled;
// an instruction moves through stage 1, stage 2 and then the output register, which
// presents its report beat. The register file and the data memory are synchronous RAMs;
// the register read is issued on the accept edge, the memory access on the edge at which
// the instruction leaves stage 1, and the register write-back happens on the edge at
// which the result enters the output register. Results still in flight are forwarded
// to younger instructions, so back-to-back dependent instructions never wait.
// After reset the unit runs a clearing pass over the 256 data memory words that zeroes
// them and loads the register reset values (0, 4, 9, 10, then zeros); in_ready stays low
// until it has finished. An output register holds a finished result, so a new instruction
// is taken while an earlier report still waits for out_ready.

module toy_cpu_execute_step_unit
	import tces_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         instr_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         op_kind,
	output logic [2:0]         dest_index,
	output logic signed [31:0] dest_value,
	output logic               reg_written,
	output logic signed [31:0] mem_address,
	output logic               mem_written,
	output logic               out_of_range
);

	// Clearing pass after reset.
	logic [CLR_W-1:0] clr_cnt_q;
	logic             clr_done_q;

	// Stage 1: register operands available.
	logic             valid_s1;
	logic             fresh_s1;
	op_t              op_s1;
	logic [RF_AW-1:0] ra_s1;
	logic [RF_AW-1:0] rb_s1;
	word_t            va_hold_s1;
	word_t            vb_hold_s1;

	// Stage 2: memory read data available.
	logic             valid_s2;
	op_t              op_s2;
	logic [RF_AW-1:0] ra_s2;
	word_t            res_s2;
	word_t            addr_s2;
	logic             regw_s2;
	logic             memw_s2;
	logic             oor_s2;

	// Output register.
	logic             out_valid_q;
	op_t              op_q;
	logic [RF_AW-1:0] dest_index_q;
	logic [OUT_W-1:0] dest_value_q;
	logic             reg_written_q;
	logic [OUT_W-1:0] mem_address_q;
	logic             mem_written_q;
	logic             oor_q;

	// Handshake and flow.
	logic  accept;
	logic  out_free;
	logic  s2_adv;
	logic  s2_free;
	logic  s1_adv;
	logic  s1_free;

	// Datapath.
	word_t  rf_rd_a;
	word_t  rf_rd_b;
	rf_wr_t rf_wr;
	word_t  s2_wval;
	word_t  dm_rdata;
	word_t  va_eff;
	word_t  vb_eff;
	word_t  va;
	word_t  vb;
	word_t  res_s1;
	logic   ls_s1;
	logic   ok_s1;
	logic   dm_we;
	logic [MEM_AW-1:0] dm_waddr;
	word_t  dm_wdata;
	logic   dm_re;
	logic   clr_rf;
	logic   clr_dm;

	// Flow control: each stage moves on when the one after it is empty or moving.
	assign out_free = !out_valid_q || out_ready;
	assign s2_adv   = valid_s2 && out_free;
	assign s2_free  = !valid_s2 || s2_adv;
	assign s1_adv   = valid_s1 && s2_free;
	assign s1_free  = !valid_s1 || s1_adv;
	assign in_ready = clr_done_q && s1_free;
	assign accept   = in_valid && in_ready;

	// The clearing pass walks both stores once; the register file only needs its first entries.
	assign clr_rf = !clr_done_q && (32'(clr_cnt_q) < RF_DEPTH);
	assign clr_dm = !clr_done_q && (32'(clr_cnt_q) < MEM_WORDS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_done_q <= 1'b0;
		end else if (!clr_done_q) begin
			clr_cnt_q <= clr_cnt_q + CLR_W'(1);
			if (clr_cnt_q == CLR_W'(CLR_LEN - 1)) begin
				clr_done_q <= 1'b1;
			end
		end
	end

	// Value that the instruction in stage 2 writes back on its way out.
	assign s2_wval = (op_s2 == OP_LOAD) ? (oor_s2 ? '1 : dm_rdata) : res_s2;

	always_comb begin
		rf_wr.en   = 1'b0;
		rf_wr.idx  = ra_s2;
		rf_wr.data = s2_wval;
		if (!clr_done_q) begin
			rf_wr.en   = clr_rf;
			rf_wr.idx  = clr_cnt_q[RF_AW-1:0];
			rf_wr.data = rf_reset_value(clr_cnt_q[RF_AW-1:0]);
		end else if (s2_adv && regw_s2) begin
			rf_wr.en = 1'b1;
		end
	end

	tces_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_a_idx  (instr_byte[5:3]),
		.rd_b_idx  (instr_byte[2:0]),
		.wr        (rf_wr),
		.rd_a_data (rf_rd_a),
		.rd_b_data (rf_rd_b)
	);

	// In its first cycle the instruction takes the RAM data; while it stalls it keeps
	// its own copy, which follows every write-back to the same register.
	assign va_eff = fresh_s1 ? rf_rd_a : va_hold_s1;
	assign vb_eff = fresh_s1 ? rf_rd_b : vb_hold_s1;

	// The older instruction in stage 2 has not written back yet, so forward it.
	assign va = (valid_s2 && regw_s2 && ra_s2 == ra_s1) ? s2_wval : va_eff;
	assign vb = (valid_s2 && regw_s2 && ra_s2 == rb_s1) ? s2_wval : vb_eff;

	assign ls_s1 = (op_s1 == OP_LOAD) || (op_s1 == OP_STORE);
	assign ok_s1 = addr_in_range(vb);

	always_comb begin
		case (op_s1)
			OP_ADD:   res_s1 = va + vb;
			OP_SUB:   res_s1 = va - vb;
			OP_STORE: res_s1 = va;
			default:  res_s1 = '0;
		endcase
	end

	// Data memory port: the clearing pass or a store leaving stage 1 writes, a load leaving stage 1 reads.
	assign dm_we    = clr_done_q ? (s1_adv && op_s1 == OP_STORE && ok_s1) : clr_dm;
	assign dm_waddr = clr_done_q ? vb[MEM_AW-1:0] : clr_cnt_q[MEM_AW-1:0];
	assign dm_wdata = clr_done_q ? va : '0;
	assign dm_re    = s1_adv && op_s1 == OP_LOAD && ok_s1;

	tces_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MEM_WORDS)) u_dmem (
		.clk   (clk),
		.we    (dm_we),
		.waddr (dm_waddr),
		.wdata (dm_wdata),
		.re    (dm_re),
		.raddr (vb[MEM_AW-1:0]),
		.rdata (dm_rdata)
	);

	// Pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fresh_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			fresh_s1 <= accept;
			if (s1_free) begin
				valid_s1 <= accept;
			end
			if (s2_free) begin
				valid_s2 <= s1_adv;
			end
			if (out_free) begin
				out_valid_q <= s2_adv;
			end
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op_t'(instr_byte[7:6]);
			ra_s1 <= instr_byte[5:3];
			rb_s1 <= instr_byte[2:0];
		end
		va_hold_s1 <= (rf_wr.en && rf_wr.idx == ra_s1) ? rf_wr.data : va_eff;
		vb_hold_s1 <= (rf_wr.en && rf_wr.idx == rb_s1) ? rf_wr.data : vb_eff;

		if (s1_adv) begin
			op_s2   <= op_s1;
			ra_s2   <= ra_s1;
			res_s2  <= res_s1;
			addr_s2 <= ls_s1 ? vb : '0;
			regw_s2 <= (op_s1 != OP_STORE);
			memw_s2 <= (op_s1 == OP_STORE) && ok_s1;
			oor_s2  <= ls_s1 && !ok_s1;
		end

		if (s2_adv) begin
			op_q          <= op_s2;
			dest_index_q  <= ra_s2;
			dest_value_q  <= OUT_W'(s2_wval);
			reg_written_q <= regw_s2;
			mem_address_q <= OUT_W'(addr_s2);
			mem_written_q <= memw_s2;
			oor_q         <= oor_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign op_kind      = op_q;
	assign dest_index   = dest_index_q;
	assign dest_value   = $signed(dest_value_q);
	assign reg_written  = reg_written_q;
	assign mem_address  = $signed(mem_address_q);
	assign mem_written  = mem_written_q;
	assign out_of_range = oor_q;

	// No instruction may enter while the clearing pass is still running.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> clr_done_q)
		else $error("instruction accepted during clearing pass");

	// An instruction never both writes a register and writes memory.
	a_write_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(regw_s2 && memw_s2))
		else $error("register and memory write in the same instruction");

	// Out of range is only ever reported for loads and stores.
	a_oor_only_ls: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && oor_q) |-> (op_q == OP_LOAD || op_q == OP_STORE))
		else $error("out of range reported for arithmetic");

	// An instruction leaving stage 1 must be in stage 2 on the next cycle.
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> valid_s2)
		else $error("instruction lost between stage 1 and stage 2");

endmodule

[rtl/tces_ram.sv]
// Generic synchronous RAM: one write port, one read port, registered read data.
// A read at the address being written returns the old contents. No dependencies.
`timescale 1ns / 1ps

module tces_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/tces_regfile.sv]
// Eight-entry register file built from two RAM copies, one per read port.
// Depends on tces_pkg and tces_ram; bypasses a write that lands on the read edge.
`timescale 1ns / 1ps

module tces_regfile
	import tces_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [RF_AW-1:0] rd_a_idx,
	input  logic [RF_AW-1:0] rd_b_idx,
	input  rf_wr_t           wr,
	output word_t            rd_a_data,
	output word_t            rd_b_data
);

	logic [RF_AW-1:0] rd_a_idx_q;
	logic [RF_AW-1:0] rd_b_idx_q;
	rf_wr_t           wr_q;
	word_t            ram_a;
	word_t            ram_b;

	tces_ram #(.WIDTH(DATA_WIDTH), .DEPTH(RF_DEPTH)) u_copy_a (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.idx),
		.wdata (wr.data),
		.re    (rd_en),
		.raddr (rd_a_idx),
		.rdata (ram_a)
	);

	tces_ram #(.WIDTH(DATA_WIDTH), .DEPTH(RF_DEPTH)) u_copy_b (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.idx),
		.wdata (wr.data),
		.re    (rd_en),
		.raddr (rd_b_idx),
		.rdata (ram_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
		end else begin
			wr_q <= wr;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_idx_q <= rd_a_idx;
			rd_b_idx_q <= rd_b_idx;
		end
	end

	// The RAM returns old data when a write hits the same edge as the read.
	assign rd_a_data = (wr_q.en && wr_q.idx == rd_a_idx_q) ? wr_q.data : ram_a;
	assign rd_b_data = (wr_q.en && wr_q.idx == rd_b_idx_q) ? wr_q.data : ram_b;

endmodule

[sim/tb_toy_cpu_execute_step_unit.sv]
// Self-checking testbench for toy_cpu_execute_step_unit: a directed program, then random
// instruction streams, each checked against a predicted report beat.
// Depends on tces_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module tb_toy_cpu_execute_step_unit
	import tces_pkg::*;
();

	// Nothing may be accepted on either channel for this many cycles. The figure covers the
	// clearing pass after reset, which is the longest quiet stretch a correct unit shows,
	// plus the longest stall bursts, several times over.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 600;
	localparam int CALM_ITEMS     = 100;

	// One report beat as the unit should present it.
	typedef struct {
		op_t         op;
		logic [2:0]  dest;
		logic [31:0] value;
		logic        regw;
		logic [31:0] addr;
		logic        memw;
		logic        oor;
	} exec_report_t;

	// Tracks the architectural state of the machine and the report beats still owed by the
	// unit. Instructions are executed here in acceptance order, so the register file and
	// memory below always reflect every instruction accepted so far.
	class exec_scoreboard;
		word_t        regs [RF_DEPTH];
		word_t        dmem [MEM_WORDS];
		exec_report_t awaited_reports [$];
		int           errors;

		function new();
			foreach (dmem[i])
				dmem[i] = '0;
			foreach (regs[i])
				regs[i] = '0;
			regs[1] = 4;
			regs[2] = 9;
			regs[3] = 10;
			errors  = 0;
		endfunction

		// A word addresses memory when it is non-negative as a signed value and below the
		// memory size.
		static function bit in_memory(word_t a);
			return ($signed(a) >= 0) && ($signed(a) < MEM_WORDS);
		endfunction

		function void note_instr(logic [7:0] ins);
			exec_report_t r;
			word_t        va;
			word_t        vb;
			r.op    = op_t'(ins[7:6]);
			r.dest  = ins[5:3];
			r.value = '0;
			r.regw  = 1'b0;
			r.addr  = '0;
			r.memw  = 1'b0;
			r.oor   = 1'b0;
			// Register b is read before register a is written, so a == b needs no care.
			va = regs[ins[5:3]];
			vb = regs[ins[2:0]];
			case (r.op)
				OP_ADD: begin
					r.value = va + vb;
					r.regw  = 1'b1;
				end
				OP_SUB: begin
					r.value = va - vb;
					r.regw  = 1'b1;
				end
				OP_LOAD: begin
					r.addr = vb;
					r.regw = 1'b1;
					if (in_memory(vb)) begin
						r.value = dmem[vb[MEM_AW-1:0]];
					end else begin
						r.value = '1;
						r.oor   = 1'b1;
					end
				end
				OP_STORE: begin
					r.addr  = vb;
					r.value = va;
					if (in_memory(vb)) begin
						dmem[vb[MEM_AW-1:0]] = va;
						r.memw = 1'b1;
					end else begin
						r.oor = 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (r.regw)
				regs[ins[5:3]] = r.value;
			awaited_reports = {awaited_reports, r};
		endfunction

		function void report_field(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
					$time, field, want, got);
				errors++;
			end
		endfunction

		function void check_report(exec_report_t got);
			exec_report_t want;
			if (awaited_reports.size() == 0) begin
				$display("%0t: report beat with nothing awaited, op %0d dest %0d value 0x%08h",
					$time, got.op, got.dest, got.value);
				errors++;
				return;
			end
			want = awaited_reports.pop_front();
			report_field("op_kind", 32'(want.op), 32'(got.op));
			report_field("dest_index", 32'(want.dest), 32'(got.dest));
			report_field("dest_value", want.value, got.value);
			report_field("reg_written", 32'(want.regw), 32'(got.regw));
			report_field("mem_address", want.addr, got.addr);
			report_field("mem_written", 32'(want.memw), 32'(got.memw));
			report_field("out_of_range", 32'(want.oor), 32'(got.oor));
		endfunction
	endclass

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic [7:0]  instr_byte   = '0;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic [1:0]  op_kind;
	logic [2:0]  dest_index;
	logic [31:0] dest_value;
	logic        reg_written;
	logic [31:0] mem_address;
	logic        mem_written;
	logic        out_of_range;

	// When set, neither side idles; the closing stretch of the run runs at full rate.
	bit             calm = 1'b0;
	int             quiet_cycles = 0;
	exec_scoreboard sb;

	always #2 clk = ~clk;

	toy_cpu_execute_step_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.instr_byte   (instr_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.op_kind      (op_kind),
		.dest_index   (dest_index),
		.dest_value   (dest_value),
		.reg_written  (reg_written),
		.mem_address  (mem_address),
		.mem_written  (mem_written),
		.out_of_range (out_of_range)
	);

	// Presents one instruction beat and holds it until the unit takes it. The prediction is
	// made at the accepting edge, so the next instruction is chosen against up-to-date state.
	// The valid line is only dropped when a gap follows, which keeps back-to-back beats free
	// of a lower-and-raise within one time step.
	task automatic send_instr(input logic [7:0] ins);
		in_valid   <= 1'b1;
		instr_byte <= ins;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_instr(ins);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// Random instructions that still reach memory: register values drift far out of the
	// address range, so load and store mostly take their address from a register that
	// currently holds a valid address. Some instructions clear a register, and some add a
	// small in-range value to one, which keeps a supply of varied valid addresses.
	function automatic logic [7:0] pick_instr();
		op_t        op;
		logic [2:0] ra;
		logic [2:0] rb;
		int         roll;
		int         hits [$];
		op   = op_t'($urandom_range(0, 3));
		ra   = 3'($urandom);
		rb   = 3'($urandom);
		roll = $urandom_range(0, 99);
		for (int r = 0; r < RF_DEPTH; r++)
			if (exec_scoreboard::in_memory(sb.regs[r]))
				hits = {hits, r};
		if (roll < 8) begin
			op = OP_SUB;
			rb = ra;
		end else if (roll < 20) begin
			op = OP_ADD;
			if (hits.size() > 0)
				rb = 3'(hits[$urandom_range(0, hits.size() - 1)]);
		end else if ((op == OP_LOAD || op == OP_STORE) && hits.size() > 0
				&& $urandom_range(0, 9) < 7) begin
			rb = 3'(hits[$urandom_range(0, hits.size() - 1)]);
		end
		return {op, ra, rb};
	endfunction

	// Output side: ready in runs of random length, broken by stall bursts unless calm.
	initial begin
		@(posedge clk);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			if (!calm && $urandom_range(0, 1) == 1) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
		end
	end

	// Every accepted report beat is checked against the oldest awaited one.
	always @(posedge clk) begin
		exec_report_t got;
		if (out_valid && out_ready) begin
			got.op    = op_t'(op_kind);
			got.dest  = dest_index;
			got.value = dest_value;
			got.regw  = reg_written;
			got.addr  = mem_address;
			got.memw  = mem_written;
			got.oor   = out_of_range;
			sb.check_report(got);
		end
	end

	// Watchdog: a hung handshake on either side ends the run as a failure.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("toy_cpu_execute_step_unit regression: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		// The directed program walks through the special cases in order. Register values
		// after reset are r1 = 4, r2 = 9, r3 = 10 and zeros elsewhere.
		logic [7:0] directed_prog [$] = '{
			8'h00,  // add r0, r0: the all-zero instruction
			8'h41,  // sub r0 = r0 - r1 gives -4
			8'h98,  // load r3 from a negative address: out of range, r3 becomes all ones
			8'hC1,  // store r0 to word 4
			8'h91,  // load r2 from word 4, reading back -4
			8'hC0,  // store r0 to itself as address: negative, so dropped
			8'hFF,  // store r7 to word r7: same register, address 0
			8'hBF,  // load r7 from word r7: same register
			8'h7F,  // sub r7 = r7 - r7
			8'h09, 8'h09, 8'h09, 8'h09, 8'h09, 8'h09,  // double r1 up to 256
			8'hA1,  // load r4 from word 256: just past the end, r4 becomes all ones
			8'hE9,  // store r5 to word 256: dropped
			8'h0C,  // add r1 = 256 + (-1) gives the last word, 255
			8'hD9,  // store r3 to word 255
			8'hB1,  // load r6 from word 255
			8'h1B   // add r3 = r3 + r3 with r3 all ones: wraps
		};

		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_prog[i])
			send_instr(directed_prog[i]);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			send_instr(pick_instr());
		end
		// The final beat may still be held if no gap followed it.
		in_valid <= 1'b0;

		while (sb.awaited_reports.size() != 0)
			@(posedge clk);
		// Wait on to catch any stray report beat.
		repeat (10) @(posedge clk);

		if (sb.errors == 0) begin
			$display("toy_cpu_execute_step_unit regression: pass");
		end else begin
			$display("toy_cpu_execute_step_unit regression: fail");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/tces_pkg.sv
rtl/tces_ram.sv
rtl/tces_regfile.sv
rtl/toy_cpu_execute_step_unit.sv
sim/tb_toy_cpu_execute_step_unit.sv
